FILE: sv/pce_pkg.sv
// shared types, constants and helper functions of the piecewise curve evaluator
`default_nettype none

package pce_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int STEP_W     = 5;
    localparam int ITER_W     = 5;
    localparam int DATA_W     = 32;
    localparam int PW         = DATA_W + 1;
    localparam int TW         = FRAC_BITS + 1;
    localparam int BW         = FRAC_BITS + 3;
    localparam int MA_W       = BW + 1;
    localparam int MB_W       = PW + 1;
    localparam int MP_W       = MA_W + MB_W;
    localparam int ACC_W      = MP_W + 2;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int BEZ_LAST   = 10;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_COUNT = 2'd1;
    localparam logic [1:0] CFG_ITER  = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_P,
        S_LD_P,
        S_LD_N,
        S_TEST,
        S_DIV,
        S_LMUL,
        S_LRES,
        S_RD_H1,
        S_LD_H1,
        S_LD_H2,
        S_XBEZ,
        S_BIS,
        S_YBEZ,
        S_CRES,
        S_FALL_RD,
        S_FALL_LD,
        S_FALL_RES,
        S_FIN
    } pce_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_LMUL,
        OP_RES_LIN,
        OP_RES_PY,
        OP_BIS_INIT,
        OP_BEZ,
        OP_BIS_UPD,
        OP_RES_CUB
    } pce_op_t;

    typedef enum logic [2:0] {
        LD_NONE,
        LD_P,
        LD_N,
        LD_H1,
        LD_H2
    } pce_ld_t;

    typedef struct packed {
        pce_op_t            op;
        pce_ld_t            ld;
        logic [IDX_W-1:0]   rd_addr;
        logic               wr_en;
        logic               out_load;
        logic               miss;
        logic               use_y;
        logic [STEP_W-1:0]  bez_step;
    } pce_cmd_t;

    typedef struct packed {
        logic x_ge_p;
        logic x_gt_p;
        logic x_lt_n;
    } pce_stat_t;

    // divide by ONE, rounding toward zero
    function automatic logic signed [ACC_W-1:0] trunc_one(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] tmp;
        tmp = v[ACC_W-1] ? (v + $signed(ACC_W'(ONE - 1))) : v;
        return tmp >>> FRAC_BITS;
    endfunction

    function automatic logic [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-DATA_W:0] top;
        top = v[ACC_W-1:DATA_W-1];
        if ((&top) || !(|top)) begin
            return v[DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/pce_datapath.sv
// point table, divider, shared multiplier and bisection registers
`default_nettype none

module pce_datapath (
    input  wire                              aclk,
    input  pce_pkg::pce_cmd_t                cmd,
    output pce_pkg::pce_stat_t               stat,
    input  wire [pce_pkg::IDX_W-1:0]         s_entry_index,
    input  wire [pce_pkg::DATA_W-1:0]        s_entry_x,
    input  wire [pce_pkg::DATA_W-1:0]        s_entry_y,
    input  wire [pce_pkg::DATA_W-1:0]        s_query_x,
    output logic [pce_pkg::DATA_W-1:0]       m_curve_value,
    output logic                             m_fell_through
);

    localparam int F   = pce_pkg::FRAC_BITS;
    localparam int DW  = pce_pkg::DATA_W;
    localparam int PW  = pce_pkg::PW;
    localparam int TW  = pce_pkg::TW;
    localparam int BW  = pce_pkg::BW;
    localparam int MAW = pce_pkg::MA_W;
    localparam int MBW = pce_pkg::MB_W;
    localparam int MPW = pce_pkg::MP_W;
    localparam int AW  = pce_pkg::ACC_W;

    logic [2*DW-1:0] mem [pce_pkg::MAX_POINTS];
    logic [2*DW-1:0] rd_reg;

    logic [TW-1:0] x_reg;
    logic signed [DW-1:0] px_reg, py_reg, nx_reg, ny_reg;
    logic signed [DW-1:0] h1x_reg, h1y_reg, h2x_reg, h2y_reg;

    logic [PW:0]   r_reg;
    logic [F-1:0]  q_reg;

    logic [TW-1:0] t_reg, lo_reg, up_reg, s2_reg, t2_reg;
    logic [BW-1:0] b0_reg, b1_reg, b2_reg, b3_reg;
    logic signed [MPW-1:0] mul_reg;
    logic signed [AW-1:0]  acc_reg;
    logic [DW-1:0] res_reg;

    logic signed [PW-1:0] xe, pxe, nxe, pye, nye, dx, dw, dy;
    logic signed [PW-1:0] p0, p1, p2, p3;
    logic [TW-1:0] s_val;
    logic [BW-1:0] s2x3, sx3;
    logic [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [MPW-1:0] mul_p;
    logic signed [AW-1:0] mul_ext, gx, xa, lin_sum;
    logic gx_gt;
    logic [PW:0] r_sh;
    logic r_ge;
    logic [TW:0] sum_lo, sum_up;
    logic [TW-1:0] xq;

    // clamp query to [0, ONE]
    always_comb begin
        if (s_query_x[DW-1]) begin
            xq = '0;
        end else if (s_query_x > DW'(pce_pkg::ONE)) begin
            xq = TW'(pce_pkg::ONE);
        end else begin
            xq = s_query_x[TW-1:0];
        end
    end

    always_comb begin
        xe  = $signed({{(PW-TW){1'b0}}, x_reg});
        pxe = PW'(px_reg);
        nxe = PW'(nx_reg);
        pye = PW'(py_reg);
        nye = PW'(ny_reg);
        dx  = xe - pxe;
        dw  = nxe - pxe;
        dy  = nye - pye;
        stat.x_ge_p = xe >= pxe;
        stat.x_gt_p = xe > pxe;
        stat.x_lt_n = xe < nxe;
    end

    // bezier control points, x or y
    always_comb begin
        if (cmd.use_y) begin
            p0 = pye;
            p1 = pye + PW'(h1y_reg);
            p2 = nye + PW'(h2y_reg);
            p3 = nye;
        end else begin
            p0 = pxe;
            p1 = pxe + PW'(h1x_reg);
            p2 = nxe + PW'(h2x_reg);
            p3 = nxe;
        end
    end

    always_comb begin
        s_val = TW'(pce_pkg::ONE) - t_reg;
        s2x3  = BW'(s2_reg) + BW'({s2_reg, 1'b0});
        sx3   = BW'(s_val) + BW'({s_val, 1'b0});
        mul_a = '0;
        mul_b = '0;
        if (cmd.op == pce_pkg::OP_LMUL) begin
            mul_a = MAW'(q_reg);
            mul_b = MBW'(dy);
        end else begin
            case (cmd.bez_step)
                5'd0: begin mul_a = MAW'(s_val);  mul_b = $signed(MBW'(s_val));  end
                5'd1: begin mul_a = MAW'(t_reg);  mul_b = $signed(MBW'(t_reg));  end
                5'd2: begin mul_a = MAW'(s2_reg); mul_b = $signed(MBW'(s_val));  end
                5'd3: begin mul_a = MAW'(s2x3);   mul_b = $signed(MBW'(t_reg));  end
                5'd4: begin mul_a = MAW'(sx3);    mul_b = $signed(MBW'(t2_reg)); end
                5'd5: begin mul_a = MAW'(t2_reg); mul_b = $signed(MBW'(t_reg));  end
                5'd6: begin mul_a = MAW'(b0_reg); mul_b = MBW'(p0); end
                5'd7: begin mul_a = MAW'(b1_reg); mul_b = MBW'(p1); end
                5'd8: begin mul_a = MAW'(b2_reg); mul_b = MBW'(p2); end
                5'd9: begin mul_a = MAW'(b3_reg); mul_b = MBW'(p3); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        mul_p   = $signed(mul_a) * mul_b;
        mul_ext = AW'(mul_reg);
        gx      = pce_pkg::trunc_one(acc_reg);
        xa      = $signed({{(AW-TW){1'b0}}, x_reg});
        gx_gt   = gx > xa;
        lin_sum = pce_pkg::trunc_one(mul_ext) + AW'(py_reg);
        r_sh    = {r_reg[PW-1:0], 1'b0};
        r_ge    = r_sh >= {1'b0, dw};
        sum_lo  = {1'b0, t_reg} + {1'b0, lo_reg};
        sum_up  = {1'b0, t_reg} + {1'b0, up_reg};
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[s_entry_index] <= {s_entry_y, s_entry_x};
        end
        rd_reg <= mem[cmd.rd_addr];
    end

    always_ff @(posedge aclk) begin
        mul_reg <= mul_p;
        case (cmd.ld)
            pce_pkg::LD_P:  begin px_reg  <= rd_reg[DW-1:0]; py_reg  <= rd_reg[2*DW-1:DW]; end
            pce_pkg::LD_N:  begin nx_reg  <= rd_reg[DW-1:0]; ny_reg  <= rd_reg[2*DW-1:DW]; end
            pce_pkg::LD_H1: begin h1x_reg <= rd_reg[DW-1:0]; h1y_reg <= rd_reg[2*DW-1:DW]; end
            pce_pkg::LD_H2: begin h2x_reg <= rd_reg[DW-1:0]; h2y_reg <= rd_reg[2*DW-1:DW]; end
            default: ;
        endcase
        case (cmd.op)
            pce_pkg::OP_START: x_reg <= xq;
            pce_pkg::OP_DIV_INIT: begin
                r_reg <= {1'b0, dx};
                q_reg <= '0;
            end
            pce_pkg::OP_DIV_STEP: begin
                r_reg <= r_ge ? (r_sh - {1'b0, dw}) : r_sh;
                q_reg <= {q_reg[F-2:0], r_ge};
            end
            pce_pkg::OP_RES_LIN: res_reg <= pce_pkg::sat32(lin_sum);
            pce_pkg::OP_RES_PY:  res_reg <= py_reg;
            pce_pkg::OP_RES_CUB: res_reg <= pce_pkg::sat32(gx);
            pce_pkg::OP_BIS_INIT: begin
                lo_reg <= '0;
                up_reg <= TW'(pce_pkg::ONE);
                t_reg  <= TW'(pce_pkg::ONE / 2);
            end
            pce_pkg::OP_BIS_UPD: begin
                if (gx_gt) begin
                    up_reg <= t_reg;
                    t_reg  <= sum_lo[TW:1];
                end else begin
                    lo_reg <= t_reg;
                    t_reg  <= sum_up[TW:1];
                end
            end
            pce_pkg::OP_BEZ: begin
                case (cmd.bez_step)
                    5'd1:  s2_reg  <= mul_reg[F +: TW];
                    5'd2:  t2_reg  <= mul_reg[F +: TW];
                    5'd3:  b0_reg  <= mul_reg[F +: BW];
                    5'd4:  b1_reg  <= mul_reg[F +: BW];
                    5'd5:  b2_reg  <= mul_reg[F +: BW];
                    5'd6:  b3_reg  <= mul_reg[F +: BW];
                    5'd7:  acc_reg <= mul_ext;
                    5'd8, 5'd9, 5'd10: acc_reg <= acc_reg + mul_ext;
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (cmd.out_load) begin
            m_curve_value  <= res_reg;
            m_fell_through <= cmd.miss;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pce_ctrl.sv
// sequencer: configuration registers, segment search, divide and bisection control
`default_nettype none

module pce_ctrl (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        cfg_wr_en,
    input  wire [1:0]                  cfg_index,
    input  wire [6:0]                  cfg_data,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire                        s_func,
    output logic                       m_valid,
    input  wire                        m_ready,
    input  pce_pkg::pce_stat_t         stat,
    output pce_pkg::pce_cmd_t          cmd
);

    localparam int CW = pce_pkg::CNT_W;
    localparam int SW = pce_pkg::STEP_W;
    localparam int IW = pce_pkg::ITER_W;

    pce_pkg::pce_state_t state_reg, state_next;
    logic          mode_reg;
    logic [CW-1:0] count_reg;
    logic [IW-1:0] iter_cfg_reg;
    logic [CW-1:0] pidx_reg, pidx_next, nidx_reg, nidx_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] iter_reg, iter_next;
    logic          miss_reg, miss_next;
    logic          m_valid_reg, m_valid_next;

    logic [CW-1:0] n_eff, seg_step, extra, fall_idx, h1_idx, h2_idx;
    logic          seg_ok, hit, accept, out_free;

    always_comb begin
        if (count_reg < CW'(2)) begin
            n_eff = CW'(2);
        end else if (count_reg > CW'(pce_pkg::MAX_POINTS)) begin
            n_eff = CW'(pce_pkg::MAX_POINTS);
        end else begin
            n_eff = count_reg;
        end
        seg_step = mode_reg ? CW'(3) : CW'(1);
        extra    = mode_reg ? CW'(2) : CW'(1);
        // last usable next point index differs by mode
        seg_ok   = (nidx_reg + extra) <= n_eff;
        fall_idx = n_eff - extra;
        h1_idx   = pidx_reg + CW'(1);
        h2_idx   = pidx_reg + CW'(2);
        hit      = (mode_reg ? stat.x_gt_p : stat.x_ge_p) && stat.x_lt_n;
        accept   = s_valid && (state_reg == pce_pkg::S_IDLE);
        out_free = !m_valid_reg || m_ready;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        pidx_next  = pidx_reg;
        nidx_next  = nidx_reg;
        cnt_next   = cnt_reg;
        iter_next  = iter_reg;
        miss_next  = miss_reg;
        case (state_reg)
            pce_pkg::S_IDLE: begin
                if (accept && s_func == pce_pkg::FUNC_QUERY) begin
                    pidx_next  = mode_reg ? CW'(1) : CW'(0);
                    nidx_next  = mode_reg ? CW'(4) : CW'(1);
                    state_next = pce_pkg::S_RD_P;
                end
            end
            pce_pkg::S_RD_P:  state_next = seg_ok ? pce_pkg::S_LD_P : pce_pkg::S_FALL_RD;
            pce_pkg::S_LD_P:  state_next = pce_pkg::S_LD_N;
            pce_pkg::S_LD_N:  state_next = pce_pkg::S_TEST;
            pce_pkg::S_TEST: begin
                cnt_next = '0;
                if (mode_reg && stat.x_ge_p && !stat.x_gt_p) begin
                    miss_next  = 1'b0;
                    state_next = pce_pkg::S_FIN;
                end else if (hit) begin
                    state_next = mode_reg ? pce_pkg::S_RD_H1 : pce_pkg::S_DIV;
                end else begin
                    pidx_next  = pidx_reg + seg_step;
                    nidx_next  = nidx_reg + seg_step;
                    state_next = pce_pkg::S_RD_P;
                end
            end
            pce_pkg::S_DIV: begin
                cnt_next = cnt_reg + SW'(1);
                if (cnt_reg == SW'(pce_pkg::FRAC_BITS - 1)) begin
                    state_next = pce_pkg::S_LMUL;
                end
            end
            pce_pkg::S_LMUL: state_next = pce_pkg::S_LRES;
            pce_pkg::S_LRES: begin
                miss_next  = 1'b0;
                state_next = pce_pkg::S_FIN;
            end
            pce_pkg::S_RD_H1: state_next = pce_pkg::S_LD_H1;
            pce_pkg::S_LD_H1: state_next = pce_pkg::S_LD_H2;
            pce_pkg::S_LD_H2: begin
                cnt_next   = '0;
                iter_next  = iter_cfg_reg;
                state_next = (iter_cfg_reg == '0) ? pce_pkg::S_YBEZ : pce_pkg::S_XBEZ;
            end
            pce_pkg::S_XBEZ: begin
                cnt_next = cnt_reg + SW'(1);
                if (cnt_reg == SW'(pce_pkg::BEZ_LAST)) begin
                    cnt_next   = '0;
                    state_next = pce_pkg::S_BIS;
                end
            end
            pce_pkg::S_BIS: begin
                iter_next  = iter_reg - IW'(1);
                state_next = (iter_reg == IW'(1)) ? pce_pkg::S_YBEZ : pce_pkg::S_XBEZ;
            end
            pce_pkg::S_YBEZ: begin
                cnt_next = cnt_reg + SW'(1);
                if (cnt_reg == SW'(pce_pkg::BEZ_LAST)) begin
                    cnt_next   = '0;
                    state_next = pce_pkg::S_CRES;
                end
            end
            pce_pkg::S_CRES: begin
                miss_next  = 1'b0;
                state_next = pce_pkg::S_FIN;
            end
            pce_pkg::S_FALL_RD:  state_next = pce_pkg::S_FALL_LD;
            pce_pkg::S_FALL_LD:  state_next = pce_pkg::S_FALL_RES;
            pce_pkg::S_FALL_RES: begin
                miss_next  = 1'b1;
                state_next = pce_pkg::S_FIN;
            end
            pce_pkg::S_FIN: begin
                if (out_free) begin
                    state_next = pce_pkg::S_IDLE;
                end
            end
            default: state_next = pce_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd          = '0;
        cmd.op       = pce_pkg::OP_NONE;
        cmd.ld       = pce_pkg::LD_NONE;
        cmd.miss     = miss_reg;
        cmd.bez_step = cnt_reg;
        s_ready      = 1'b0;
        case (state_reg)
            pce_pkg::S_IDLE: begin
                s_ready   = 1'b1;
                cmd.wr_en = accept && (s_func == pce_pkg::FUNC_WRITE);
                if (accept && s_func == pce_pkg::FUNC_QUERY) begin
                    cmd.op = pce_pkg::OP_START;
                end
            end
            pce_pkg::S_RD_P: cmd.rd_addr = pidx_reg[pce_pkg::IDX_W-1:0];
            pce_pkg::S_LD_P: begin
                cmd.ld      = pce_pkg::LD_P;
                cmd.rd_addr = nidx_reg[pce_pkg::IDX_W-1:0];
            end
            pce_pkg::S_LD_N: cmd.ld = pce_pkg::LD_N;
            pce_pkg::S_TEST: begin
                if (mode_reg && stat.x_ge_p && !stat.x_gt_p) begin
                    cmd.op = pce_pkg::OP_RES_PY;
                end else begin
                    cmd.op = pce_pkg::OP_DIV_INIT;
                end
            end
            pce_pkg::S_DIV:   cmd.op = pce_pkg::OP_DIV_STEP;
            pce_pkg::S_LMUL:  cmd.op = pce_pkg::OP_LMUL;
            pce_pkg::S_LRES:  cmd.op = pce_pkg::OP_RES_LIN;
            pce_pkg::S_RD_H1: cmd.rd_addr = h1_idx[pce_pkg::IDX_W-1:0];
            pce_pkg::S_LD_H1: begin
                cmd.ld      = pce_pkg::LD_H1;
                cmd.rd_addr = h2_idx[pce_pkg::IDX_W-1:0];
            end
            pce_pkg::S_LD_H2: begin
                cmd.ld = pce_pkg::LD_H2;
                cmd.op = pce_pkg::OP_BIS_INIT;
            end
            pce_pkg::S_XBEZ: cmd.op = pce_pkg::OP_BEZ;
            pce_pkg::S_BIS:  cmd.op = pce_pkg::OP_BIS_UPD;
            pce_pkg::S_YBEZ: begin
                cmd.op    = pce_pkg::OP_BEZ;
                cmd.use_y = 1'b1;
            end
            pce_pkg::S_CRES:     cmd.op = pce_pkg::OP_RES_CUB;
            pce_pkg::S_FALL_RD:  cmd.rd_addr = fall_idx[pce_pkg::IDX_W-1:0];
            pce_pkg::S_FALL_LD:  cmd.ld = pce_pkg::LD_P;
            pce_pkg::S_FALL_RES: cmd.op = pce_pkg::OP_RES_PY;
            pce_pkg::S_FIN:      cmd.out_load = out_free;
            default: ;
        endcase
        m_valid_next = cmd.out_load || (m_valid_reg && !m_ready);
        m_valid      = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pce_pkg::S_IDLE;
            mode_reg     <= 1'b0;
            count_reg    <= CW'(2);
            iter_cfg_reg <= IW'(16);
            pidx_reg     <= '0;
            nidx_reg     <= '0;
            cnt_reg      <= '0;
            iter_reg     <= '0;
            miss_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pidx_reg    <= pidx_next;
            nidx_reg    <= nidx_next;
            cnt_reg     <= cnt_next;
            iter_reg    <= iter_next;
            miss_reg    <= miss_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    pce_pkg::CFG_MODE:  mode_reg     <= cfg_data[0];
                    pce_pkg::CFG_COUNT: count_reg    <= cfg_data[CW-1:0];
                    pce_pkg::CFG_ITER:  iter_cfg_reg <= cfg_data[IW-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/piecewise_curve_evaluator.sv
// top level of the piecewise linear / cubic bezier curve evaluator
//
//  channel   dir  handshake                 contents
//  s_axis    in   s_axis_tvalid/tready      table write or query
//  m_axis    out  m_axis_tvalid/tready      curve value per query
//  cfg       in   cfg_wr_en                 mode, point count, bisection steps
//
// a write transfer goes straight into the table; a query searches one segment at a time
// (one table read port), then linear: divide, multiply, result; cubic: two handle reads,
// an x evaluation per bisection step, then one for y (one shared multiplier)
// reset is synchronous; the table keeps its contents and is undefined until written
// a stalled result sits in the output register; the next transfer is taken meanwhile
`default_nettype none

module piecewise_curve_evaluator (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          cfg_wr_en,
    input  wire [1:0]    cfg_index,
    input  wire [6:0]    cfg_data,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // entry_index, entry_x, entry_y, query_x, zero fill
    input  wire [103:0]  s_axis_tdata,
    // func
    input  wire          s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // curve_value
    output logic [31:0]  m_axis_tdata,
    // fell_through
    output logic         m_axis_tuser
);

    pce_pkg::pce_cmd_t  cmd;
    pce_pkg::pce_stat_t stat;

    pce_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_func    (s_axis_tuser),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pce_datapath u_dp (
        .aclk           (aclk),
        .cmd            (cmd),
        .stat           (stat),
        .s_entry_index  (s_axis_tdata[5:0]),
        .s_entry_x      (s_axis_tdata[37:6]),
        .s_entry_y      (s_axis_tdata[69:38]),
        .s_query_x      (s_axis_tdata[101:70]),
        .m_curve_value  (m_axis_tdata),
        .m_fell_through (m_axis_tuser)
    );

endmodule

`default_nettype wire

FILE: dv/piecewise_curve_evaluator_test.sv
// testbench of the piecewise curve evaluator: directed and random curves, checked against a predictor
`timescale 1ns / 1ps

module piecewise_curve_evaluator_test;

    localparam int  STALL_LIMIT = 5000;
    localparam int  SETTLE      = 20;
    localparam longint ONE_L    = longint'(pce_pkg::ONE);

    typedef struct {
        logic [31:0] curve_value;
        logic        fell_through;
    } curve_result_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_wr_en = 1'b0;
    logic [1:0]    cfg_index = '0;
    logic [6:0]    cfg_data = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [103:0]  s_axis_tdata = '0;
    logic          s_axis_tuser = 1'b0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [31:0]   m_axis_tdata;
    logic          m_axis_tuser;

    piecewise_curve_evaluator dut (.*);

    // predictor copy of the block state
    longint        point_x [pce_pkg::MAX_POINTS];
    longint        point_y [pce_pkg::MAX_POINTS];
    logic          mode_cubic = 1'b0;
    int            count_reg = 2;
    int            steps_reg = 16;

    curve_result_t pending_values[$];
    bit            no_idle = 1'b0;
    int            errors = 0;
    int            stall_cycles = 0;
    int            n_queries = 0;
    int            n_writes = 0;
    int            n_fell = 0;

    initial forever #6 aclk = ~aclk;

    function automatic longint bezier_at(longint unsigned t, longint p0, longint p1,
                                         longint p2, longint p3);
        longint unsigned s, s2, t2;
        longint b0, b1, b2, b3;
        s  = longint'(pce_pkg::ONE) - t;
        s2 = (s * s) >> pce_pkg::FRAC_BITS;
        t2 = (t * t) >> pce_pkg::FRAC_BITS;
        b0 = longint'((s2 * s) >> pce_pkg::FRAC_BITS);
        b1 = longint'((3 * s2 * t) >> pce_pkg::FRAC_BITS);
        b2 = longint'((3 * s * t2) >> pce_pkg::FRAC_BITS);
        b3 = longint'((t2 * t) >> pce_pkg::FRAC_BITS);
        return (b0 * p0 + b1 * p1 + b2 * p2 + b3 * p3) / ONE_L;
    endfunction

    function automatic curve_result_t curve_at(logic signed [31:0] qx);
        curve_result_t r;
        int n, a, b;
        longint x, v, px, nx, p1x, p2x;
        longint unsigned lo, hi, t;
        bit hit;
        n = count_reg < 2 ? 2 :
            (count_reg > pce_pkg::MAX_POINTS ? pce_pkg::MAX_POINTS : count_reg);
        x = longint'(qx);
        if (x < 0) x = 0;
        if (x > ONE_L) x = ONE_L;
        hit = 0;
        if (!mode_cubic) begin
            v = point_y[n-1];
            for (int i = 0; i + 1 < n && !hit; i++) begin
                px = point_x[i];
                nx = point_x[i+1];
                if (x >= px && x < nx) begin
                    hit = 1;
                    v = point_y[i] + ((point_y[i+1] - point_y[i]) * (((x - px) * ONE_L) /
                        (nx - px))) / ONE_L;
                end
            end
        end else begin
            v = point_y[n-2];
            for (int i = 0; i + 1 < n / 3 && !hit; i++) begin
                a  = i * 3 + 1;
                b  = i * 3 + 4;
                px = point_x[a];
                nx = point_x[b];
                if (x == px) begin
                    hit = 1;
                    v = point_y[a];
                end else if (x > px && x < nx) begin
                    hit = 1;
                    p1x = px + point_x[a+1];
                    p2x = nx + point_x[a+2];
                    lo = 0;
                    hi = pce_pkg::ONE;
                    t = pce_pkg::ONE / 2;
                    for (int k = 0; k < steps_reg; k++) begin
                        if (bezier_at(t, px, p1x, p2x, nx) > x) begin
                            hi = t;
                            t = (t + lo) / 2;
                        end else begin
                            lo = t;
                            t = (t + hi) / 2;
                        end
                    end
                    v = bezier_at(t, point_y[a], point_y[a] + point_y[a+1],
                                  point_y[b] + point_y[a+2], point_y[b]);
                end
            end
        end
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        r.curve_value  = v[31:0];
        r.fell_through = !hit;
        return r;
    endfunction

    task automatic send_item(logic func, logic [5:0] idx, logic [31:0] ex, logic [31:0] ey,
                             logic [31:0] qx);
        if (!no_idle && $urandom_range(99) < 8) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {2'b00, qx, ey, ex, idx};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (func == pce_pkg::FUNC_WRITE) begin
            point_x[idx] = longint'($signed(ex));
            point_y[idx] = longint'($signed(ey));
            n_writes++;
        end else begin
            pending_values.insert(pending_values.size(), curve_at(qx));
            n_queries++;
        end
    endtask

    task automatic write_point(int idx, int ex, int ey);
        send_item(pce_pkg::FUNC_WRITE, idx[5:0], ex, ey, $urandom);
    endtask

    task automatic query_curve(int qx);
        send_item(pce_pkg::FUNC_QUERY, 6'($urandom), $urandom, $urandom, qx);
    endtask

    // stop sending and let every queued result come back
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_values.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_config(logic [1:0] idx, int value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[6:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            pce_pkg::CFG_MODE:  mode_cubic = value[0];
            pce_pkg::CFG_COUNT: count_reg = value & 7'h7f;
            pce_pkg::CFG_ITER:  steps_reg = value & 5'h1f;
            default: ;
        endcase
    endtask

    // sorted anchors over roughly [0, ONE]; cubic handles around each anchor
    task automatic build_curve(int count);
        int x, stepmax;
        x = -int'($urandom_range(300));
        stepmax = (2 * pce_pkg::ONE) / (count < 3 ? 3 : count) + 1;
        for (int i = 0; i < count; i++) begin
            if (!mode_cubic) begin
                write_point(i, x, $urandom_range(1) ? int'($urandom) :
                            $urandom_range(4 * pce_pkg::ONE));
                x += $urandom_range(1, stepmax);
            end else if (i % 3 == 1) begin
                write_point(i, x, int'($urandom_range(8 * pce_pkg::ONE)) - 4 * pce_pkg::ONE);
                x += 3 * $urandom_range(1, stepmax);
            end else begin
                write_point(i, (i % 3 == 0 ? -1 : 1) * int'($urandom_range(pce_pkg::ONE / 4)),
                            $urandom_range(9) == 0 ? int'($urandom) :
                            int'($urandom_range(2 * pce_pkg::ONE)) - pce_pkg::ONE);
            end
        end
    endtask

    function automatic int pick_query();
        case ($urandom_range(9))
            0:       return int'($urandom);
            1, 2:    return int'(point_x[$urandom_range(pce_pkg::MAX_POINTS - 1)]);
            default: return int'($urandom_range(pce_pkg::ONE + 1000)) - 500;
        endcase
    endfunction

    task automatic test_linear_edges;
        set_config(pce_pkg::CFG_MODE, 0);
        set_config(pce_pkg::CFG_COUNT, 2);
        write_point(0, 0, 32'sh8000_0000);
        write_point(1, pce_pkg::ONE, 32'sh7fff_ffff);
        query_curve(32'sh8000_0000);
        query_curve(32'sh7fff_ffff);
        query_curve(0);
        query_curve(pce_pkg::ONE);
        query_curve(pce_pkg::ONE / 2);
        query_curve(pce_pkg::ONE - 1);
        set_config(pce_pkg::CFG_COUNT, 0);
        query_curve(pce_pkg::ONE / 3);
        set_config(pce_pkg::CFG_COUNT, 127);
        query_curve(pce_pkg::ONE / 5);
        query_curve(pce_pkg::ONE);
    endtask

    task automatic test_cubic_edges;
        set_config(pce_pkg::CFG_MODE, 1);
        set_config(pce_pkg::CFG_COUNT, 8);
        set_config(pce_pkg::CFG_ITER, 0);
        write_point(0, -pce_pkg::ONE / 8, 32'sh7fff_ffff);
        write_point(1, 0, 100);
        write_point(2, 32'sh7fff_ffff, 32'sh7fff_ffff);
        write_point(3, 32'sh8000_0000, 32'sh7fff_ffff);
        write_point(4, pce_pkg::ONE, -pce_pkg::ONE);
        write_point(5, pce_pkg::ONE / 8, 3 * pce_pkg::ONE);
        write_point(6, 0, 777);
        write_point(7, 0, 999);
        query_curve(0);
        query_curve(pce_pkg::ONE / 2);
        set_config(pce_pkg::CFG_ITER, 31);
        query_curve(pce_pkg::ONE / 2);
        query_curve(pce_pkg::ONE);
        write_point(2, pce_pkg::ONE / 4, 32'sh7fff_ffff);
        write_point(3, -pce_pkg::ONE / 4, 32'sh7fff_ffff);
        query_curve(pce_pkg::ONE / 3);
        query_curve(-5);
        write_point(63, 32'sh8000_0000, 32'sh7fff_ffff);
    endtask

    task automatic test_random_curves;
        int cnt, q;
        for (int ph = 0; ph < 10; ph++) begin
            no_idle = (ph == 2);
            set_config(pce_pkg::CFG_MODE, $urandom_range(1));
            case (ph % 4)
                0:       cnt = 64;
                1:       cnt = 2 + $urandom_range(4);
                default: cnt = $urandom_range(2, 30);
            endcase
            if (mode_cubic && cnt < 6) cnt = 6;
            if (mode_cubic && $urandom_range(3) != 0) cnt -= cnt % 3;
            set_config(pce_pkg::CFG_COUNT, cnt);
            set_config(pce_pkg::CFG_ITER, ph == 1 ? 31 : $urandom_range(0, 20));
            build_curve(cnt);
            q = 0;
            while (q < 120) begin
                if ($urandom_range(19) == 0) begin
                    // stray write that may break ordering
                    write_point($urandom_range(pce_pkg::MAX_POINTS - 1), $urandom, $urandom);
                end else begin
                    query_curve(pick_query());
                    q++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    always @(posedge aclk) begin
        m_axis_tready <= no_idle || $urandom_range(99) >= 8;
    end

    always @(posedge aclk) begin
        curve_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_values.size() == 0) begin
                $error("unexpected result transfer: curve_value %h", m_axis_tdata);
                errors++;
            end else begin
                want = pending_values.pop_front();
                if (m_axis_tuser) n_fell++;
                if (m_axis_tdata !== want.curve_value) begin
                    $error("curve_value expected %h actual %h", want.curve_value, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== want.fell_through) begin
                    $error("fell_through expected %b actual %b", want.fell_through,
                           m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en
            || !aresetn) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles > STALL_LIMIT) begin
                $display("piecewise_curve_evaluator_test NOT OK");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < pce_pkg::MAX_POINTS; i++) write_point(i, $urandom, $urandom);
        test_linear_edges();
        test_cubic_edges();
        test_random_curves();
        drain();
        repeat (50) @(posedge aclk);
        if (pending_values.size() != 0) begin
            $error("%0d results never arrived", pending_values.size());
            errors++;
        end
        $display("covered %0d queries (%0d fell through) and %0d table writes", n_queries,
                 n_fell, n_writes);
        $display("linear and cubic modes, clamped counts, 0..31 bisection steps");
        if (errors == 0) begin
            $display("piecewise_curve_evaluator_test OK");
        end else begin
            $display("piecewise_curve_evaluator_test NOT OK");
        end
        $finish;
    end

endmodule
